[src/gbte_pkg.sv]
// Package for the gap buffer text editor: payload structs, mode and status codes.
// No dependencies.
`timescale 1ns / 1ps
package gbte_pkg;
  localparam int unsigned DEPTH = 4096;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned OW = 13;

  localparam logic [3:0] MODE_INSERT = 4'd0;
  localparam logic [3:0] MODE_BKSP   = 4'd1;
  localparam logic [3:0] MODE_DELRNG = 4'd2;
  localparam logic [3:0] MODE_MOVE   = 4'd3;
  localparam logic [3:0] MODE_READ   = 4'd4;
  localparam logic [3:0] MODE_LSTART = 4'd5;
  localparam logic [3:0] MODE_LEND   = 4'd6;
  localparam logic [3:0] MODE_WSTART = 4'd7;
  localparam logic [3:0] MODE_WEND   = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_CP    = 2'd3;

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef struct packed {
    logic [3:0]    mode;
    logic [20:0]   codepoint;
    logic [OW-1:0] offset_a;
    logic [OW-1:0] offset_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [OW-1:0] position;
    logic [7:0]    read_byte;
    logic [OW-1:0] cursor_now;
    logic [OW-1:0] length_now;
    logic          modified;
  } out_item_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;
endpackage

[src/gap_buffer_text_editor.sv]
// Gap buffer text editor: cursor-based UTF-8 text store in one memory.
// Moves, errors and no-op modes go straight to the result; other modes read, copy or scan bytes
// through a read state and a check state per byte, then a result state.
// Insert shifts each tail byte up with a read and a check, then writes each encoded byte.
// Throughput: one transaction at a time; the next is accepted the cycle after the result leaves.
// Reset: cursor, length and modified flag clear; the store holds garbage until written.
`timescale 1ns / 1ps
module gap_buffer_text_editor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gbte_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gbte_pkg::out_item_t out_data
);
  localparam int unsigned OW = gbte_pkg::OW;
  localparam int unsigned AW = gbte_pkg::AW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;  // read issued, data next cycle
  localparam logic [3:0] S_CHK  = 4'd2;  // data valid, act on it
  localparam logic [3:0] S_INS  = 4'd3;  // write encoded bytes
  localparam logic [3:0] S_OUT  = 4'd4;
  localparam logic [3:0] S_W2   = 4'd5;  // word start second phase
  localparam logic [3:0] S_WE2  = 4'd6;  // word end trailing blanks

  // Internal walk phases kept in mode_r
  localparam logic [3:0] M_WEND_GAP    = 4'd14;  // word end: skip spaces and tabs
  localparam logic [3:0] M_WSTART_WORD = 4'd15;  // word start: skip non-blanks

  logic [3:0]    state_r, state_nxt;
  logic [OW-1:0] cursor_r, cursor_nxt, len_r, len_nxt;
  logic          dirty_r, dirty_nxt;
  logic [3:0]    mode_r, mode_nxt;
  logic [OW-1:0] i_r, i_nxt;    // walk index
  logic [OW-1:0] j_r, j_nxt;    // second index / copy destination
  logic [OW-1:0] lim_r, lim_nxt;
  logic [2:0]    n_r, n_nxt;
  logic [31:0]   enc_r, enc_nxt;
  gbte_pkg::out_item_t res_r, res_nxt;
  logic          ov_r, ov_nxt;
  gbte_pkg::mem_req_t req;
  logic [7:0]    rdata;

  gbte_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  assign in_stall  = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_data  = res_r;

  function automatic logic blank_nl(input logic [7:0] c);
    return (c == gbte_pkg::CH_SP) || (c == gbte_pkg::CH_NL);
  endfunction

  // Sequence one transaction through the store
  always_comb begin
    logic [20:0] cp;
    logic [OW:0] need;
    logic [OW-1:0] a, b;
    state_nxt  = state_r;
    cursor_nxt = cursor_r;
    len_nxt    = len_r;
    dirty_nxt  = dirty_r;
    mode_nxt   = mode_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    lim_nxt    = lim_r;
    n_nxt      = n_r;
    enc_nxt    = enc_r;
    res_nxt    = res_r;
    ov_nxt     = ov_r && out_stall;
    req        = '0;
    req.raddr  = i_r[AW-1:0];
    cp = in_data.codepoint;
    a  = in_data.offset_a;
    b  = in_data.offset_b;
    need = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          mode_nxt = in_data.mode;
          res_nxt  = '0;
          state_nxt = S_OUT;
          unique case (in_data.mode)
            gbte_pkg::MODE_INSERT: begin
              if (cp > 21'h10FFFF) begin
                res_nxt.status = gbte_pkg::ST_CP;
              end else begin
                if (cp <= 21'h7F) begin
                  n_nxt = 3'd1; enc_nxt = {cp[7:0], 24'd0};
                end else if (cp <= 21'h7FF) begin
                  n_nxt = 3'd2;
                  enc_nxt = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'd0};
                end else if (cp <= 21'hFFFF) begin
                  n_nxt = 3'd3;
                  enc_nxt = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'd0};
                end else begin
                  n_nxt = 3'd4;
                  enc_nxt = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                             2'b10, cp[5:0]};
                end
                need = {1'b0, len_r} + {{(OW-2){1'b0}}, n_nxt};
                if (need > (OW+1)'(gbte_pkg::DEPTH)) begin
                  res_nxt.status = gbte_pkg::ST_FULL;
                end else begin
                  // shift tail up, from the top down
                  i_nxt = len_r;
                  state_nxt = (len_r == cursor_r) ? S_INS : S_RD;
                  j_nxt = '0;
                end
              end
            end
            gbte_pkg::MODE_BKSP: begin
              if (cursor_r != '0) begin
                i_nxt = cursor_r - 1'b1;
                state_nxt = S_RD;
              end
            end
            gbte_pkg::MODE_DELRNG: begin
              if (a > len_r || b > len_r) res_nxt.status = gbte_pkg::ST_RANGE;
              else if (a < b) begin
                // range reaching the end leaves no tail to copy
                if (b == len_r) begin
                  len_nxt = a; cursor_nxt = a; dirty_nxt = 1'b1;
                end else begin
                  lim_nxt = a; j_nxt = a; i_nxt = b; state_nxt = S_RD;
                end
              end
            end
            gbte_pkg::MODE_MOVE: begin
              if (a > len_r) res_nxt.status = gbte_pkg::ST_RANGE;
              else cursor_nxt = a;
            end
            gbte_pkg::MODE_READ: begin
              if (a >= len_r) res_nxt.status = gbte_pkg::ST_RANGE;
              else begin i_nxt = a; state_nxt = S_RD; end
            end
            gbte_pkg::MODE_LSTART, gbte_pkg::MODE_WSTART: begin
              if (a > len_r) res_nxt.status = gbte_pkg::ST_RANGE;
              else if (a != '0) begin i_nxt = a - 1'b1; j_nxt = a; state_nxt = S_RD; end
            end
            gbte_pkg::MODE_LEND, gbte_pkg::MODE_WEND: begin
              if (a > len_r) res_nxt.status = gbte_pkg::ST_RANGE;
              else if (a < len_r) begin i_nxt = a; j_nxt = a; state_nxt = S_RD; end
              else res_nxt.position = a;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        req.raddr = i_r[AW-1:0];
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_RD;
        unique case (mode_r)
          gbte_pkg::MODE_INSERT: begin
            // on entry i_r is the source+1 position; each byte i is then moved up by n
            req.we = 1'b0;
            if (j_r == '0) begin
              // first visit: fetch byte i-1
              i_nxt = i_r - 1'b1; j_nxt = 13'd1;
            end else begin
              req.we = 1'b1;
              req.waddr = AW'(i_r + {{(OW-3){1'b0}}, n_r});
              req.wdata = rdata;
              if (i_r == cursor_r) state_nxt = S_INS;
              else i_nxt = i_r - 1'b1;
              j_nxt = '0;
              i_nxt = (i_r == cursor_r) ? cursor_r : i_r - 1'b1;
              j_nxt = 13'd1;
            end
          end
          gbte_pkg::MODE_BKSP: begin
            if (i_r != '0 && rdata[7:6] == 2'b10) i_nxt = i_r - 1'b1;
            else begin
              lim_nxt = i_r; j_nxt = i_r; i_nxt = cursor_r;
              mode_nxt = gbte_pkg::MODE_DELRNG;
              state_nxt = (cursor_r == len_r) ? S_OUT : S_RD;
              if (cursor_r == len_r) begin
                len_nxt = len_r - (cursor_r - i_r);
                cursor_nxt = i_r; dirty_nxt = 1'b1;
                res_nxt.cursor_now = '0;
              end
            end
          end
          gbte_pkg::MODE_DELRNG: begin
            // copy byte i to j
            req.we = 1'b1; req.waddr = j_r[AW-1:0]; req.wdata = rdata;
            i_nxt = i_r + 1'b1; j_nxt = j_r + 1'b1;
            if (i_r + 1'b1 == len_r) begin
              state_nxt = S_OUT;
              len_nxt = j_r + 1'b1;
              cursor_nxt = lim_r; dirty_nxt = 1'b1;
            end
          end
          gbte_pkg::MODE_READ: begin
            res_nxt.read_byte = rdata; state_nxt = S_OUT;
          end
          gbte_pkg::MODE_LSTART: begin
            if (rdata == gbte_pkg::CH_NL) begin
              res_nxt.position = i_r + 1'b1; state_nxt = S_OUT;
            end else if (i_r == '0) state_nxt = S_OUT;
            else i_nxt = i_r - 1'b1;
          end
          gbte_pkg::MODE_LEND: begin
            if (rdata == gbte_pkg::CH_NL || i_r + 1'b1 == len_r) begin
              res_nxt.position = (rdata == gbte_pkg::CH_NL) ? i_r : len_r;
              state_nxt = S_OUT;
            end else i_nxt = i_r + 1'b1;
          end
          gbte_pkg::MODE_WSTART: begin
            // phase 1: skip blanks; j_r holds candidate position
            if (blank_nl(rdata)) begin
              j_nxt = i_r;
              if (i_r == '0) begin res_nxt.position = '0; state_nxt = S_OUT; end
              else i_nxt = i_r - 1'b1;
            end else begin
              mode_nxt = M_WSTART_WORD; j_nxt = i_r;
              if (i_r == '0) begin res_nxt.position = '0; state_nxt = S_OUT; end
              else i_nxt = i_r - 1'b1;
            end
          end
          gbte_pkg::MODE_WEND: begin
            if (i_r == j_r && rdata == gbte_pkg::CH_NL) begin
              res_nxt.position = i_r + 1'b1; state_nxt = S_OUT;
            end else if (!blank_nl(rdata)) begin
              if (i_r + 1'b1 == len_r) begin res_nxt.position = len_r; state_nxt = S_OUT; end
              else i_nxt = i_r + 1'b1;
            end else begin
              mode_nxt = M_WEND_GAP;
              state_nxt = S_CHK;
            end
          end
          M_WEND_GAP: begin
            if (rdata == gbte_pkg::CH_SP || rdata == gbte_pkg::CH_TAB) begin
              if (i_r + 1'b1 == len_r) begin res_nxt.position = len_r; state_nxt = S_OUT; end
              else i_nxt = i_r + 1'b1;
            end else begin res_nxt.position = i_r; state_nxt = S_OUT; end
          end
          M_WSTART_WORD: begin
            // phase 2 of word start: skip non-blanks
            if (blank_nl(rdata)) begin res_nxt.position = j_r; state_nxt = S_OUT; end
            else begin
              j_nxt = i_r;
              if (i_r == '0) begin res_nxt.position = '0; state_nxt = S_OUT; end
              else i_nxt = i_r - 1'b1;
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_INS: begin
        // write encoded bytes at cursor, one per cycle
        req.we = 1'b1; req.waddr = cursor_r[AW-1:0]; req.wdata = enc_r[31:24];
        enc_nxt = {enc_r[23:0], 8'd0};
        n_nxt = n_r - 1'b1;
        cursor_nxt = cursor_r + 1'b1; len_nxt = len_r + 1'b1; dirty_nxt = 1'b1;
        if (n_r == 3'd1) state_nxt = S_OUT;
      end
      S_OUT: begin
        res_nxt.cursor_now = cursor_r;
        res_nxt.length_now = len_r;
        res_nxt.modified   = dirty_r;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state; control clears on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cursor_r <= '0; len_r <= '0; dirty_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cursor_r <= cursor_nxt; len_r <= len_nxt;
      dirty_r <= dirty_nxt; ov_r <= ov_nxt;
    end
    mode_r <= mode_nxt; i_r <= i_nxt; j_r <= j_nxt; lim_r <= lim_nxt;
    n_r <= n_nxt; enc_r <= enc_nxt; res_r <= res_nxt;
  end

  // Checks
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= OW'(gbte_pkg::DEPTH)) else $error("length above capacity");
  a_cur_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> cursor_r <= len_r) else $error("cursor past text");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("accepting while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data)) else $error("result changed");
endmodule

[src/gbte_ram.sv]
// Text store: single write port, single registered read port.
// Depends on gbte_pkg.
`timescale 1ns / 1ps
module gbte_ram (
  input  logic              clk,
  input  gbte_pkg::mem_req_t req,
  output logic [7:0]        rdata
);
  logic [7:0] mem [gbte_pkg::DEPTH];

  // Write and read the store
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

[bench/gbte_checker.sv]
// Checker for the gap buffer text editor: watches both channels, predicts each result
// from its own copy of the text store and compares. Depends on gbte_pkg.
`timescale 1ns / 1ps
module gbte_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  gbte_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  gbte_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count
);
  logic [7:0] text_q [gbte_pkg::DEPTH];
  int unsigned cur_q, len_q;
  logic dirty_q;
  gbte_pkg::out_item_t result_fifo [$];

  function automatic logic is_ws(logic [7:0] c);
    return c == gbte_pkg::CH_SP || c == gbte_pkg::CH_NL;
  endfunction

  // Drop bytes [s,e) and put the cursor at s.
  task automatic cut_span(int unsigned s, int unsigned e);
    for (int unsigned j = s; j + (e - s) < len_q; j++) text_q[j] = text_q[j + (e - s)];
    len_q = len_q - (e - s);
    cur_q = s;
    dirty_q = 1'b1;
  endtask

  task automatic apply_edit(gbte_pkg::in_item_t it);
    gbte_pkg::out_item_t r;
    logic [7:0] enc [4];
    int unsigned n, i, k, a, b;
    logic [20:0] cp;
    r = '0;
    n = 0;
    a = 32'(it.offset_a);
    b = 32'(it.offset_b);
    cp = it.codepoint;
    case (it.mode)
      gbte_pkg::MODE_INSERT: begin
        if (cp > 21'h10FFFF) r.status = gbte_pkg::ST_CP;
        else begin
          if (cp <= 21'h7F) begin
            n = 1; enc[0] = cp[7:0];
          end else if (cp <= 21'h7FF) begin
            n = 2; enc[0] = {3'b110, cp[10:6]}; enc[1] = {2'b10, cp[5:0]};
          end else if (cp <= 21'hFFFF) begin
            n = 3; enc[0] = {4'b1110, cp[15:12]}; enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
          end else begin
            n = 4; enc[0] = {5'b11110, cp[20:18]}; enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]}; enc[3] = {2'b10, cp[5:0]};
          end
          if (len_q + n > gbte_pkg::DEPTH) r.status = gbte_pkg::ST_FULL;
          else begin
            for (int j = int'(len_q) - 1; j >= int'(cur_q); j--)
              text_q[j + int'(n)] = text_q[j];
            for (int j = 0; j < int'(n); j++) text_q[cur_q + j] = enc[j];
            cur_q += n;
            len_q += n;
            dirty_q = 1'b1;
          end
        end
      end
      gbte_pkg::MODE_BKSP: begin
        if (cur_q > 0) begin
          k = cur_q - 1;
          while (k > 0 && (text_q[k] & 8'hC0) == 8'h80) k--;
          cut_span(k, cur_q);
        end
      end
      gbte_pkg::MODE_DELRNG: begin
        if (b > len_q || a > len_q) r.status = gbte_pkg::ST_RANGE;
        else if (a < b) cut_span(a, b);
      end
      gbte_pkg::MODE_MOVE: begin
        if (a > len_q) r.status = gbte_pkg::ST_RANGE;
        else cur_q = a;
      end
      gbte_pkg::MODE_READ: begin
        if (a >= len_q) r.status = gbte_pkg::ST_RANGE;
        else r.read_byte = text_q[a];
      end
      gbte_pkg::MODE_LSTART: begin
        if (a > len_q) r.status = gbte_pkg::ST_RANGE;
        else begin
          for (i = a; i > 0; i--) if (text_q[i - 1] == gbte_pkg::CH_NL) break;
          r.position = 13'(i);
        end
      end
      gbte_pkg::MODE_LEND: begin
        if (a > len_q) r.status = gbte_pkg::ST_RANGE;
        else begin
          i = a;
          while (i < len_q && text_q[i] != gbte_pkg::CH_NL) i++;
          r.position = 13'(i);
        end
      end
      gbte_pkg::MODE_WSTART: begin
        if (a > len_q) r.status = gbte_pkg::ST_RANGE;
        else begin
          i = a;
          while (i > 0 && is_ws(text_q[i - 1])) i--;
          while (i > 0 && !is_ws(text_q[i - 1])) i--;
          r.position = 13'(i);
        end
      end
      gbte_pkg::MODE_WEND: begin
        if (a > len_q) r.status = gbte_pkg::ST_RANGE;
        else begin
          i = a;
          if (i < len_q && text_q[i] == gbte_pkg::CH_NL) r.position = 13'(i + 1);
          else begin
            while (i < len_q && !is_ws(text_q[i])) i++;
            while (i < len_q && (text_q[i] == gbte_pkg::CH_SP ||
                                 text_q[i] == gbte_pkg::CH_TAB)) i++;
            r.position = 13'(i);
          end
        end
      end
      default: ;
    endcase
    r.cursor_now = 13'(cur_q);
    r.length_now = 13'(len_q);
    r.modified = dirty_q;
    result_fifo.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Predict on each input transaction, compare on each output transaction.
  always @(posedge clk) begin
    gbte_pkg::out_item_t w;
    if (!rst_n) begin
      cur_q = 0; len_q = 0; dirty_q = 1'b0; fail_count = 0;
      result_fifo.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (result_fifo.size() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          w = result_fifo.pop_front();
          if (out_data.status !== w.status)
            report_mismatch("status", int'(out_data.status), int'(w.status));
          if (out_data.position !== w.position)
            report_mismatch("position", int'(out_data.position), int'(w.position));
          if (out_data.read_byte !== w.read_byte)
            report_mismatch("read_byte", int'(out_data.read_byte), int'(w.read_byte));
          if (out_data.cursor_now !== w.cursor_now)
            report_mismatch("cursor_now", int'(out_data.cursor_now), int'(w.cursor_now));
          if (out_data.length_now !== w.length_now)
            report_mismatch("length_now", int'(out_data.length_now), int'(w.length_now));
          if (out_data.modified !== w.modified)
            report_mismatch("modified", int'(out_data.modified), int'(w.modified));
        end
      end
      if (in_valid && !in_stall) apply_edit(in_data);
    end
    pending_count = result_fifo.size();
  end
endmodule

[bench/gap_buffer_text_editor_tb.sv]
// Testbench top for the gap buffer text editor: drives edit transactions with random
// gaps and stalls, and gives the verdict. Depends on gbte_pkg, gbte_checker and the editor.
`timescale 1ns / 1ps
module gap_buffer_text_editor_tb;
  localparam int IDLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gbte_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gbte_pkg::out_item_t out_data;
  int fail_count, pending_count;
  int send_idle_pct = 0, recv_idle_pct = 0;
  logic hold_off = 1'b0;
  int idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  gap_buffer_text_editor dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  gbte_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Stall the result channel at random, or solidly during a hold-off.
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offer one transaction, hold it until accepted, then drop valid.
  task automatic send_edit(logic [3:0] m, logic [20:0] cp, logic [12:0] a, logic [12:0] b);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_data <= '{mode: m, codepoint: cp, offset_a: a, offset_b: b};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [20:0] pick_cp();
    case ($urandom_range(9))
      0: return 21'h0A;
      1: return 21'h20;
      2: return 21'h09;
      3: return 21'($urandom_range(32'h7FF, 32'h80));
      4: return 21'($urandom_range(32'hFFFF, 32'h800));
      5: return 21'($urandom_range(32'h10FFFF, 32'h10000));
      6: return 21'($urandom);
      default: return 21'($urandom_range(32'h7E, 32'h21));
    endcase
  endfunction

  function automatic logic [12:0] pick_off(int len);
    case ($urandom_range(9))
      0: return 13'($urandom);
      1: return 13'(len + int'($urandom_range(2)));
      2: return '0;
      default: return 13'($urandom_range(32'(len)));
    endcase
  endfunction

  task automatic random_phase(int count);
    int len;
    logic [3:0] m;
    for (int n = 0; n < count; n++) begin
      len = int'(chk.len_q);
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: m = gbte_pkg::MODE_INSERT;
        7, 8: m = gbte_pkg::MODE_BKSP;
        9: m = gbte_pkg::MODE_DELRNG;
        10, 11: m = gbte_pkg::MODE_MOVE;
        12, 13: m = gbte_pkg::MODE_READ;
        14: m = gbte_pkg::MODE_LSTART;
        15: m = gbte_pkg::MODE_LEND;
        16: m = gbte_pkg::MODE_WSTART;
        17: m = gbte_pkg::MODE_WEND;
        default: m = 4'($urandom_range(15));
      endcase
      send_edit(m, pick_cp(), pick_off(len), pick_off(len));
    end
  endtask

  // Wait until every predicted result has been seen.
  task automatic drain();
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every mode, UTF-8 widths, error and edge cases.
    send_edit(gbte_pkg::MODE_BKSP, '0, '0, '0);
    send_edit(gbte_pkg::MODE_READ, '0, '0, '0);
    send_edit(gbte_pkg::MODE_INSERT, 21'h41, '0, '0);
    send_edit(gbte_pkg::MODE_INSERT, 21'h7FF, '0, '0);
    send_edit(gbte_pkg::MODE_INSERT, 21'hFFFF, '0, '0);
    send_edit(gbte_pkg::MODE_INSERT, 21'h10FFFF, '0, '0);
    send_edit(gbte_pkg::MODE_INSERT, 21'h110000, '0, '0);
    send_edit(gbte_pkg::MODE_INSERT, 21'h1FFFFF, '0, '0);
    send_edit(gbte_pkg::MODE_INSERT, 21'h0A, '0, '0);
    send_edit(gbte_pkg::MODE_INSERT, 21'h20, '0, '0);
    send_edit(gbte_pkg::MODE_INSERT, 21'h09, '0, '0);
    send_edit(gbte_pkg::MODE_INSERT, 21'h7A, '0, '0);
    send_edit(gbte_pkg::MODE_READ, '0, 13'd1, '0);
    send_edit(gbte_pkg::MODE_READ, '0, 13'h1FFF, '0);
    send_edit(gbte_pkg::MODE_LSTART, '0, 13'd14, '0);
    send_edit(gbte_pkg::MODE_LEND, '0, '0, '0);
    send_edit(gbte_pkg::MODE_WSTART, '0, 13'd14, '0);
    send_edit(gbte_pkg::MODE_WEND, '0, 13'd10, '0);
    send_edit(gbte_pkg::MODE_WEND, '0, 13'd4096, '0);
    send_edit(gbte_pkg::MODE_MOVE, '0, 13'd4096, '0);
    send_edit(gbte_pkg::MODE_MOVE, '0, 13'd6, '0);
    send_edit(gbte_pkg::MODE_BKSP, '0, '0, '0);
    send_edit(gbte_pkg::MODE_DELRNG, '0, 13'd3, 13'd1);
    send_edit(gbte_pkg::MODE_DELRNG, '0, '0, 13'h1FFF);
    send_edit(gbte_pkg::MODE_DELRNG, '0, 13'd1, 13'd3);
    send_edit(4'hF, 21'h1FFFFF, 13'h1FFF, 13'h1FFF);

    send_idle_pct = 27; recv_idle_pct = 46;
    random_phase(150);

    // Long receiver hold-off while the sender keeps offering.
    hold_off <= 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      random_phase(6);
    join
    drain();

    send_idle_pct = 46; recv_idle_pct = 27;
    random_phase(150);
    drain();

    // Neither side idles; read address 4095 and delete [0,4096), both range errors here.
    send_idle_pct = 0; recv_idle_pct = 0;
    send_edit(gbte_pkg::MODE_READ, '0, 13'd4095, '0);
    send_edit(gbte_pkg::MODE_DELRNG, '0, '0, 13'd4096);
    random_phase(110);

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[gap_buffer_text_editor.f]
src/gbte_pkg.sv
src/gbte_ram.sv
src/gap_buffer_text_editor.sv
bench/gbte_checker.sv
bench/gap_buffer_text_editor_tb.sv
